### src/pmer_pkg.sv
// Package for the partition mode-entry register block.
// Holds beat structs, command codes, register map constants and queue sizing.
// No dependencies.
package pmer_pkg;

    // Partition index width that the 12-bit offset can reach.
    localparam int unsigned PIDX_W = 3;

    localparam logic [15:0] KEY_VALUE    = 16'h5AF0;
    localparam logic [15:0] KEY_INVERTED = 16'hA50F;

    localparam logic [11:0] PART_BASE = 12'h100;
    localparam logic [8:0]  OFF_CONF  = 9'h000;
    localparam logic [8:0]  OFF_PEND  = 9'h004;
    localparam logic [8:0]  OFF_STAT  = 9'h008;
    localparam logic [8:0]  OFF_BSTAT = 9'h010;
    localparam logic [8:0]  OFF_BEN   = 9'h030;

    localparam logic [2:0] BIT_MASK   = 3'b101;
    localparam logic [2:0] CFG_RST_P0 = 3'b001;
    localparam logic [2:0] CFG_RST_PN = 3'b100;

    localparam int unsigned QDEPTH = 2;

    typedef struct packed {
        logic        opcode;
        logic [11:0] byte_offset;
        logic [31:0] write_value;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] read_value;
        logic        changes_applied;
    } out_beat_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_KEY_ARM,
        CMD_KEY_INV,
        CMD_KEY_OTHER,
        CMD_CONF,
        CMD_PEND,
        CMD_STAT,
        CMD_BSTAT,
        CMD_BEN
    } cmd_kind_t;

    typedef struct packed {
        logic              wr;
        cmd_kind_t         kind;
        logic [PIDX_W-1:0] part;
        logic [31:0]       wdata;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

### src/pmer_front.sv
// Front end: accepts input beats and classifies each into a command.
// Depends on pmer_pkg.
module pmer_front #(
    parameter int unsigned PARTITIONS = 4
) (
    input  logic              s_valid,
    output logic              s_ready,
    input  pmer_pkg::in_beat_t s_data,
    input  pmer_pkg::q_stat_t q_stat,
    output logic              q_push,
    output pmer_pkg::cmd_t    q_cmd
);
    import pmer_pkg::*;

    localparam logic [PIDX_W:0] PART_LIM = (PIDX_W + 1)'(PARTITIONS);

    logic [11:0]       word_off;
    logic [11:0]       rel;
    logic [PIDX_W-1:0] pidx;
    logic              mapped;

    assign s_ready  = !q_stat.full;
    assign q_push   = s_valid && !q_stat.full;
    assign word_off = {s_data.byte_offset[11:2], 2'b00};
    assign rel      = word_off - PART_BASE;
    assign pidx     = rel[11:9];
    assign mapped   = (word_off >= PART_BASE) && ({1'b0, pidx} < PART_LIM);

    always_comb begin
        q_cmd.wr    = s_data.opcode;
        q_cmd.part  = pidx;
        q_cmd.wdata = s_data.write_value;
        q_cmd.kind  = CMD_NONE;
        if (word_off == 12'h000) begin
            if (s_data.opcode) begin
                if (s_data.write_value[15:0] == KEY_VALUE) begin
                    q_cmd.kind = CMD_KEY_ARM;
                end else if (s_data.write_value[15:0] == KEY_INVERTED) begin
                    q_cmd.kind = CMD_KEY_INV;
                end else begin
                    q_cmd.kind = CMD_KEY_OTHER;
                end
            end
        end else if (mapped) begin
            case (rel[8:0])
                OFF_CONF:  q_cmd.kind = CMD_CONF;
                OFF_PEND:  q_cmd.kind = CMD_PEND;
                OFF_STAT:  q_cmd.kind = CMD_STAT;
                OFF_BSTAT: q_cmd.kind = CMD_BSTAT;
                OFF_BEN:   q_cmd.kind = CMD_BEN;
                default:   q_cmd.kind = CMD_NONE;
            endcase
        end
    end

endmodule

### src/pmer_fifo.sv
// Short command queue between front and back ends.
// Depends on pmer_pkg (cmd_t, q_stat_t, QDEPTH).
module pmer_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  pmer_pkg::cmd_t    push_cmd,
    input  logic              pop,
    output pmer_pkg::cmd_t    pop_cmd,
    output pmer_pkg::q_stat_t q_stat
);
    import pmer_pkg::*;

    localparam int unsigned AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int unsigned CW = $clog2(QDEPTH + 1);

    cmd_t          mem_reg [QDEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign pop_cmd      = mem_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == CW'(QDEPTH));
    assign q_stat.empty = (count_reg == '0);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### src/pmer_back.sv
// Back end: holds the partition register state, executes queued commands
// and registers the result beat. Depends on pmer_pkg.
module pmer_back #(
    parameter int unsigned PARTITIONS = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  pmer_pkg::q_stat_t   q_stat,
    input  pmer_pkg::cmd_t      q_cmd,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output pmer_pkg::out_beat_t m_data
);
    import pmer_pkg::*;

    localparam int unsigned PW = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;

    logic [2:0]  cfg_reg  [PARTITIONS];
    logic [2:0]  cfg_next [PARTITIONS];
    logic [2:0]  pend_reg [PARTITIONS];
    logic [2:0]  pend_next[PARTITIONS];
    logic [2:0]  stat_reg [PARTITIONS];
    logic [2:0]  stat_next[PARTITIONS];
    logic [31:0] ben_reg  [PARTITIONS];
    logic [31:0] ben_next [PARTITIONS];
    logic [31:0] bst_reg  [PARTITIONS];
    logic [31:0] bst_next [PARTITIONS];
    logic        armed_reg, armed_next;
    logic        out_valid_reg, out_valid_next;
    out_beat_t   out_data_reg, out_data_next;

    logic          fire;
    logic [PW-1:0] pidx;
    logic [31:0]   rd;
    logic          applied;
    logic          pend_any;

    assign fire    = !q_stat.empty && (!out_valid_reg || m_ready);
    assign q_pop   = fire;
    assign pidx    = q_cmd.part[PW-1:0];
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_comb begin
        logic [2:0] ap_mask;
        logic [2:0] ap_stat;
        ap_mask    = '0;
        ap_stat    = '0;
        cfg_next   = cfg_reg;
        pend_next  = pend_reg;
        stat_next  = stat_reg;
        ben_next   = ben_reg;
        bst_next   = bst_reg;
        armed_next = armed_reg;
        rd         = '0;
        applied    = 1'b0;
        if (fire) begin
            case (q_cmd.kind)
                CMD_KEY_ARM: begin
                    armed_next = 1'b1;
                end
                CMD_KEY_INV: begin
                    if (armed_reg) begin
                        for (int p = 0; p < PARTITIONS; p++) begin
                            ap_mask      = pend_reg[p] & BIT_MASK;
                            ap_stat      = ((stat_reg[p] & ~ap_mask) | (cfg_reg[p] & ap_mask))
                                           & BIT_MASK;
                            stat_next[p] = ap_stat;
                            bst_next[p]  = ap_stat[0] ? ben_reg[p] : '0;
                            pend_next[p] = '0;
                        end
                        armed_next = 1'b0;
                        applied    = 1'b1;
                    end
                end
                CMD_KEY_OTHER: begin
                    armed_next = 1'b0;
                end
                CMD_CONF: begin
                    if (q_cmd.wr) begin
                        cfg_next[pidx] = q_cmd.wdata[2:0] & BIT_MASK;
                    end else begin
                        rd = {29'b0, cfg_reg[pidx]};
                    end
                end
                CMD_PEND: begin
                    if (q_cmd.wr) begin
                        pend_next[pidx] = q_cmd.wdata[2:0] & BIT_MASK;
                    end else begin
                        rd = {29'b0, pend_reg[pidx]};
                    end
                end
                CMD_STAT: begin
                    if (!q_cmd.wr) begin
                        rd = {29'b0, stat_reg[pidx]};
                    end
                end
                CMD_BSTAT: begin
                    if (!q_cmd.wr) begin
                        rd = bst_reg[pidx];
                    end
                end
                CMD_BEN: begin
                    if (q_cmd.wr) begin
                        ben_next[pidx] = q_cmd.wdata;
                    end else begin
                        rd = ben_reg[pidx];
                    end
                end
                default: begin
                    rd = '0;
                end
            endcase
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (fire) begin
            out_valid_next                = 1'b1;
            out_data_next.read_value      = rd;
            out_data_next.changes_applied = applied;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_comb begin
        pend_any = 1'b0;
        for (int p = 0; p < PARTITIONS; p++) begin
            pend_any = pend_any | (|pend_reg[p]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int p = 0; p < PARTITIONS; p++) begin
                cfg_reg[p]  <= (p == 0) ? CFG_RST_P0 : CFG_RST_PN;
                stat_reg[p] <= (p == 0) ? CFG_RST_P0 : CFG_RST_PN;
                pend_reg[p] <= '0;
                ben_reg[p]  <= '0;
                bst_reg[p]  <= '0;
            end
            armed_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            cfg_reg       <= cfg_next;
            stat_reg      <= stat_next;
            pend_reg      <= pend_next;
            ben_reg       <= ben_next;
            bst_reg       <= bst_next;
            armed_reg     <= armed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    a_apply_clears_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && q_cmd.kind == CMD_KEY_INV && armed_reg) |=> !pend_any)
        else $error("pending bits survive a completed key sequence");

    a_apply_disarms: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && q_cmd.kind == CMD_KEY_INV && armed_reg)
        |=> (!armed_reg && out_valid_reg && out_data_reg.changes_applied))
        else $error("key sequence completion not reflected in state or result");

    a_applied_needs_arm: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && applied) |-> (armed_reg && q_cmd.kind == CMD_KEY_INV))
        else $error("updates applied without an armed key");

endmodule

### src/partition_mode_entry_regs_unit.sv
// Top level of the partition mode-entry register block.
// Depends on pmer_pkg, pmer_front, pmer_fifo and pmer_back.
//
// Register block for a partition mode-entry controller. Each input beat is
// one bus access (read or write at a word-aligned byte offset); each one
// returns exactly one result beat carrying read data, or zero on writes and
// unmapped offsets, plus a flag set on the write that completes the
// control-key sequence (key 0x5AF0, then 0xA50F at offset 0). Completing the
// sequence applies all pending partition updates together. One access is
// accepted per clock while the command queue is not full; each access is
// classified into a two-entry command queue, then executed into the output
// register by the execute stage, which updates all partitions in parallel;
// with m_ready held low the queue and output register absorb three beats
// before s_ready drops.
module partition_mode_entry_regs_unit #(
    parameter int unsigned PARTITIONS = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pmer_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output pmer_pkg::out_beat_t m_data
);
    import pmer_pkg::*;

    // front -> queue
    logic    push;
    cmd_t    push_cmd;
    // queue -> back
    logic    pop;
    cmd_t    pop_cmd;
    q_stat_t q_stat;

    pmer_front #(
        .PARTITIONS(PARTITIONS)
    ) u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_stat  (q_stat),
        .q_push  (push),
        .q_cmd   (push_cmd)
    );

    pmer_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .q_stat   (q_stat)
    );

    // Back end owns all register state and the result beat register.
    pmer_back #(
        .PARTITIONS(PARTITIONS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_stat  (q_stat),
        .q_cmd   (pop_cmd),
        .q_pop   (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
